// ===== rtl/ille_pkg.sv =====
// ille_pkg: shared constants for the indexed linked list engine
// command and status codes, parameter defaults; no dependencies
package ille_pkg;

  // parameter defaults
  localparam int unsigned NodesDef      = 64;
  localparam int unsigned ValueWidthDef = 64;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_TAKE   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/indexed_linked_list_engine.sv =====
// indexed_linked_list_engine: array-backed doubly linked list with free node stack
// depends on ille_pkg
//
//   channel   ports                                    transfer
//   command   start_i, busy_o, command_i, position_i,  start_i high, busy_o low
//             value_in_i
//   result    done_o, value_out_o, status_o,           done_o high, one cycle
//             element_total_o
//
// An insert or delete with a bad position, an insert into a full list or an unknown
// command reports in the cycle after its transfer. Otherwise the link walk takes one
// step per cycle over the next-link memory (up to NODES-1 steps); take and delete then
// finish in the walk state, while insert goes on to fill the new node and hook it in.
// A new command can start in the result's cycle. busy_o is high while a command is at work.
// Reset empties the list; no memory sweep is needed. Results cannot be stalled.
module indexed_linked_list_engine
  import ille_pkg::*;
#(
  parameter int unsigned NODES       = NodesDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [6:0]  position_i,
  input  logic [63:0] value_in_i,
  output logic        done_o,
  output logic [63:0] value_out_o,
  output logic [1:0]  status_o,
  output logic [5:0]  element_total_o
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned EW = (NW + 1 > 7) ? NW + 1 : 7;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_INS1 = 2'd2;
  localparam logic [1:0] S_INS2 = 2'd3;

  // memories
  logic [NW-1:0]          next_mem  [NODES];
  logic [NW-1:0]          prev_mem  [NODES];
  logic [VALUE_WIDTH-1:0] value_mem [NODES];
  logic [NW-1:0]          stack_mem [NODES];

  logic [1:0]             state_q, state_d;
  logic [1:0]             cmd_q, cmd_d;
  logic [NW-1:0]          steps_q, steps_d;
  logic [NW-1:0]          cur_q, cur_d;
  logic [NW-1:0]          head_q, head_d;
  logic [NW-1:0]          tail_q, tail_d;
  logic [NW-1:0]          cnt_q, cnt_d;
  logic [NW-1:0]          fs_cnt_q, fs_cnt_d;
  logic [NW:0]            alloc_q, alloc_d;
  logic [NW-1:0]          node_a_q, node_a_d;
  logic [NW-1:0]          node_b_q, node_b_d;
  logic [NW-1:0]          fresh_q, fresh_d;
  logic [VALUE_WIDTH-1:0] word_q, word_d;
  logic                   done_q, done_d;
  logic [VALUE_WIDTH-1:0] vout_q, vout_d;
  logic [1:0]             status_q, status_d;

  // registered read data
  logic [NW-1:0]          nxt_rd_q, prv_rd_q, fs_rd_q;
  logic [VALUE_WIDTH-1:0] val_rd_q;

  logic [NW-1:0]          cur_next, cur_prev, rd_addr, fresh;
  logic [VALUE_WIDTH-1:0] cur_val;
  logic                   rd_en;
  logic [EW-1:0]          pos_ext, cnt_ext;

  // write ports
  logic                   nw_en, pw_en, vw_en, sw_en;
  logic [NW-1:0]          nw_addr, nw_data, pw_addr, pw_data, sw_addr, sw_data;
  logic [VALUE_WIDTH-1:0] vw_data;
  logic [NW-1:0]          vw_addr;

  // links of the current node, sentinel links live in registers
  assign cur_next = (cur_q == '0) ? head_q : nxt_rd_q;
  assign cur_prev = (cur_q == '0) ? tail_q : prv_rd_q;
  assign cur_val  = (cur_q == '0) ? '0 : val_rd_q;
  assign rd_addr  = cur_next;
  assign rd_en    = (state_q == S_WALK) && (steps_q != '0);
  assign fresh    = (fs_cnt_q != '0) ? fs_rd_q : alloc_q[NW-1:0];
  assign pos_ext  = EW'(position_i);
  assign cnt_ext  = EW'(cnt_q);

  // sequencer
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    steps_d  = steps_q;
    cur_d    = cur_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    fs_cnt_d = fs_cnt_q;
    alloc_d  = alloc_q;
    node_a_d = node_a_q;
    node_b_d = node_b_q;
    fresh_d  = fresh_q;
    word_d   = word_q;
    done_d   = 1'b0;
    vout_d   = vout_q;
    status_d = status_q;
    nw_en = 1'b0; nw_addr = '0; nw_data = '0;
    pw_en = 1'b0; pw_addr = '0; pw_data = '0;
    vw_en = 1'b0; vw_addr = '0; vw_data = '0;
    sw_en = 1'b0; sw_addr = '0; sw_data = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d  = command_i;
          word_d = value_in_i[VALUE_WIDTH-1:0];
          cur_d  = '0;
          vout_d = '0;
          case (command_i)
            CMD_INSERT: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + EW'(1) || pos_ext >= EW'(NODES)) begin
                done_d   = 1'b1;
                status_d = ST_RANGE;
              end else if (cnt_q == NW'(NODES - 1)) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
              end else begin
                steps_d = NW'(pos_ext - EW'(1));
                state_d = S_WALK;
              end
            end
            CMD_DELETE: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                done_d   = 1'b1;
                status_d = ST_RANGE;
              end else begin
                steps_d = NW'(pos_ext);
                state_d = S_WALK;
              end
            end
            CMD_TAKE: begin
              steps_d = (pos_ext > cnt_ext) ? cnt_q : NW'(pos_ext);
              state_d = S_WALK;
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_RANGE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (steps_q != '0) begin
          // one link per cycle
          cur_d   = cur_next;
          steps_d = steps_q - NW'(1);
        end else begin
          case (cmd_q)
            CMD_INSERT: begin
              node_a_d = cur_q;
              node_b_d = cur_next;
              fresh_d  = fresh;
              if (fs_cnt_q != '0) begin
                fs_cnt_d = fs_cnt_q - NW'(1);
              end else begin
                alloc_d = alloc_q + (NW+1)'(1);
              end
              state_d = S_INS1;
            end
            CMD_DELETE: begin
              // unlink the victim and push it on the free stack
              if (cur_prev == '0) begin
                head_d = cur_next;
              end else begin
                nw_en = 1'b1; nw_addr = cur_prev; nw_data = cur_next;
              end
              if (cur_next == '0) begin
                tail_d = cur_prev;
              end else begin
                pw_en = 1'b1; pw_addr = cur_next; pw_data = cur_prev;
              end
              sw_en    = 1'b1;
              sw_addr  = fs_cnt_q;
              sw_data  = cur_q;
              fs_cnt_d = fs_cnt_q + NW'(1);
              cnt_d    = cnt_q - NW'(1);
              done_d   = 1'b1;
              status_d = ST_OK;
              state_d  = S_IDLE;
            end
            default: begin
              vout_d   = cur_val;
              done_d   = 1'b1;
              status_d = ST_OK;
              state_d  = S_IDLE;
            end
          endcase
        end
      end
      S_INS1: begin
        // fill the new node
        vw_en = 1'b1; vw_addr = fresh_q; vw_data = word_q;
        nw_en = 1'b1; nw_addr = fresh_q; nw_data = node_b_q;
        pw_en = 1'b1; pw_addr = fresh_q; pw_data = node_a_q;
        state_d = S_INS2;
      end
      S_INS2: begin
        // hook the new node between its neighbors
        if (node_a_q == '0) begin
          head_d = fresh_q;
        end else begin
          nw_en = 1'b1; nw_addr = node_a_q; nw_data = fresh_q;
        end
        if (node_b_q == '0) begin
          tail_d = fresh_q;
        end else begin
          pw_en = 1'b1; pw_addr = node_b_q; pw_data = fresh_q;
        end
        cnt_d    = cnt_q + NW'(1);
        done_d   = 1'b1;
        status_d = ST_OK;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      fs_cnt_q <= '0;
      alloc_q  <= (NW+1)'(1);
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      fs_cnt_q <= fs_cnt_d;
      alloc_q  <= alloc_d;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    steps_q  <= steps_d;
    cur_q    <= cur_d;
    node_a_q <= node_a_d;
    node_b_q <= node_b_d;
    fresh_q  <= fresh_d;
    word_q   <= word_d;
    vout_q   <= vout_d;
    status_q <= status_d;
  end

  // link and value memories
  always_ff @(posedge clk_i) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    if (vw_en) begin
      value_mem[vw_addr] <= vw_data;
    end
    if (rd_en) begin
      nxt_rd_q <= next_mem[rd_addr];
      prv_rd_q <= prev_mem[rd_addr];
      val_rd_q <= value_mem[rd_addr];
    end
  end

  // free stack memory, top entry read every cycle
  always_ff @(posedge clk_i) begin
    if (sw_en) begin
      stack_mem[sw_addr] <= sw_data;
    end
    fs_rd_q <= stack_mem[fs_cnt_q - NW'(1)];
  end

  // outputs
  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign value_out_o     = 64'(vout_q);
  assign status_o        = status_q;
  assign element_total_o = 6'(cnt_q);

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for indexed_linked_list_engine
// scoreboard of list operations with its own list model; depends on ille_pkg
module tb;
  import ille_pkg::*;

  localparam int unsigned NumNodes = 64;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  position;
    logic [63:0] value_in;
  } list_cmd_t;

  typedef struct packed {
    logic [63:0] value_out;
    logic [1:0]  status;
    logic [5:0]  element_total;
  } list_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = CMD_INSERT;
  logic [6:0]  position_i = '0;
  logic [63:0] value_in_i = '0;
  logic        done_o;
  logic [63:0] value_out_o;
  logic [1:0]  status_o;
  logic [5:0]  element_total_o;

  list_cmd_t pending_cmds[$];
  list_rsp_t expected_rsps[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        idle_pct = 0;
  bit        hold_off = 1'b0;
  int        idle_pct_tab[4] = '{0, 73, 0, 9};

  // list model state
  logic [63:0] mdl_value [NumNodes];
  logic [5:0]  mdl_next [NumNodes];
  logic [5:0]  mdl_prev [NumNodes];
  logic [5:0]  mdl_free [NumNodes];
  int          mdl_free_cnt;
  int          mdl_count;

  indexed_linked_list_engine u_top (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [5:0] walk_links(int steps);
    logic [5:0] node;
    node = '0;
    for (int i = 0; i < steps; i++) node = mdl_next[node];
    return node;
  endfunction

  // predicts the response of one list operation and updates the model
  function automatic list_rsp_t apply_list_op(list_cmd_t c);
    list_rsp_t  r;
    logic [5:0] fresh, pred, succ, victim;
    int         pos, steps;
    r = '0;
    pos = c.position;
    case (c.command)
      CMD_INSERT: begin
        if (pos == 0 || pos > mdl_count + 1 || pos >= NumNodes) begin
          r.status = ST_RANGE;
        end else if (mdl_free_cnt == 0) begin
          r.status = ST_FULL;
        end else begin
          mdl_free_cnt--;
          fresh = mdl_free[mdl_free_cnt];
          pred = walk_links(pos - 1);
          succ = mdl_next[pred];
          mdl_value[fresh] = c.value_in;
          mdl_next[pred] = fresh;
          mdl_prev[fresh] = pred;
          mdl_next[fresh] = succ;
          mdl_prev[succ] = fresh;
          mdl_count++;
        end
      end
      CMD_DELETE: begin
        if (pos == 0 || pos > mdl_count) begin
          r.status = ST_RANGE;
        end else begin
          victim = walk_links(pos);
          pred = mdl_prev[victim];
          succ = mdl_next[victim];
          mdl_next[pred] = succ;
          mdl_prev[succ] = pred;
          mdl_free[mdl_free_cnt] = victim;
          mdl_free_cnt++;
          mdl_count--;
        end
      end
      CMD_TAKE: begin
        steps = (pos > mdl_count) ? mdl_count : pos;
        r.value_out = mdl_value[walk_links(steps)];
      end
      default: r.status = ST_RANGE;
    endcase
    r.element_total = mdl_count[5:0];
    return r;
  endfunction

  // driver: start transfer at rising edge when start high and busy low
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      expected_rsps.push_back(apply_list_op({command_i, position_i, value_in_i}));
      void'(pending_cmds.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && busy_o)) begin
      if (pending_cmds.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
        start_i    <= 1'b1;
        command_i  <= pending_cmds[0].command;
        position_i <= pending_cmds[0].position;
        value_in_i <= pending_cmds[0].value_in;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    list_rsp_t e;
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        e = expected_rsps.pop_front();
        if (value_out_o !== e.value_out) begin
          $error("value_out expected %h actual %h", e.value_out, value_out_o);
          fail_count++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          fail_count++;
        end
        if (element_total_o !== e.element_total) begin
          $error("element_total expected %0d actual %0d", e.element_total,
                 element_total_o);
          fail_count++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic queue_op(logic [1:0] c, int p, logic [63:0] v);
    list_cmd_t x;
    x.command = c;
    x.position = p[6:0];
    x.value_in = v;
    pending_cmds.push_back(x);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || start_i)
      @(posedge clk_i);
  endtask

  // mostly well-formed ops near the current list length, some noise
  task automatic queue_random(int n);
    int len;
    int k;
    len = mdl_count + pending_cmds.size() / 3;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 8) queue_op(k[1:0] | 2'b00, $urandom_range(127), rand_word());
      else if (k < 10) queue_op(2'd3, $urandom_range(127), rand_word());
      else if (k < 45) queue_op(CMD_INSERT, $urandom_range(1, 8) + (len > 8 ? len - 8 : 0)
                                 - $urandom_range(0, 1), rand_word());
      else if (k < 70) queue_op(CMD_DELETE, $urandom_range(1, 40), rand_word());
      else queue_op(CMD_TAKE, $urandom_range(0, 64), rand_word());
    end
  endtask

  initial begin
    for (int i = 0; i < NumNodes; i++) begin
      mdl_value[i] = '0;
      mdl_next[i]  = '0;
      mdl_prev[i]  = '0;
      mdl_free[i]  = '0;
    end
    for (int i = 0; i + 1 < NumNodes; i++) mdl_free[i] = 6'(NumNodes - 1 - i);
    mdl_free_cnt = NumNodes - 1;
    mdl_count = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty list cases, range errors, fill to full, then delete and insert near the ends
    queue_op(CMD_TAKE, 0, '0);
    queue_op(CMD_TAKE, 5, '1);
    queue_op(CMD_DELETE, 1, '0);
    queue_op(CMD_INSERT, 0, '1);
    queue_op(CMD_INSERT, 2, '1);
    queue_op(2'd3, 127, '1);
    queue_op(CMD_INSERT, 1, '1);
    queue_op(CMD_INSERT, 1, 64'h0123_4567_89ab_cdef);
    queue_op(CMD_INSERT, 3, '0);
    queue_op(CMD_TAKE, 2, '0);
    queue_op(CMD_TAKE, 127, '0);
    queue_op(CMD_DELETE, 0, '0);
    queue_op(CMD_DELETE, 4, '0);
    queue_op(CMD_DELETE, 2, '0);
    queue_op(CMD_TAKE, 1, '0);
    wait_drained();
    for (int i = 0; i < 64; i++) queue_op(CMD_INSERT, i + 1, {$urandom(), $urandom()});
    queue_op(CMD_INSERT, 64, '1);
    queue_op(CMD_TAKE, 63, '0);
    wait_drained();
    queue_op(CMD_DELETE, 63, '0);
    queue_op(CMD_DELETE, 1, '0);
    queue_op(CMD_INSERT, 62, '1);
    wait_drained();

    // random phases with different sender idling
    foreach (idle_pct_tab[i]) begin
      idle_pct = idle_pct_tab[i];
      queue_random(467);
      wait_drained();
      hold_off = 1'b1;
      repeat (70) @(posedge clk_i);
      hold_off = 1'b0;
    end
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ille_pkg.sv
rtl/indexed_linked_list_engine.sv
bench/tb.sv
